FILE: rtl/core/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion shorthands used by the checker file of the stencil filter.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while reset is low
`define STF3_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("stf3 check failed");

// next-cycle implication, disabled while reset is low
`define STF3_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("stf3 check failed");

`endif

FILE: rtl/core/stf3_pkg.sv
// ----------------------------------------------------------------------------
// stf3_pkg
// Shared widths, register indexes and token types of the 3D stencil filter.
// ----------------------------------------------------------------------------
package stf3_pkg;

    localparam int SAMPLE_W   = 24;
    localparam int TIME_W     = 32;
    localparam int DIM_CFG_W  = 9;
    localparam int INT_W      = 16;
    localparam int CFG_DATA_W = 16;
    localparam int CFG_IDX_W  = 2;
    localparam int ACC_W      = 28;
    localparam int QDEPTH     = 2;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_SIZE_I   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SIZE_J   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SIZE_K   = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_INTERVAL = 2'd3;

    // input op codes
    localparam logic OP_SAMPLE = 1'b0;
    localparam logic OP_FLUSH  = 1'b1;

    // cycles the size products need after a config write
    localparam logic [1:0] CFG_SETTLE = 2'd2;

    // neighbor read slots
    localparam logic [2:0] NB_CENTER = 3'd0;
    localparam logic [2:0] NB_KP     = 3'd1;
    localparam logic [2:0] NB_KM     = 3'd2;
    localparam logic [2:0] NB_JP     = 3'd3;
    localparam logic [2:0] NB_JM     = 3'd4;
    localparam logic [2:0] NB_IP     = 3'd5;
    localparam logic [2:0] NB_IM     = 3'd6;

    // divide by twelve: x/4 then times (2^26-1)/3, one correction step
    localparam int               DIV_Y_W   = 25;
    localparam int               RECIP_SH  = 26;
    localparam logic [24:0]      RECIP3    = 25'd22369621;

    typedef struct packed {
        logic interior;
        logic last;
    } t_tok_ctl;

    localparam int TOK_CTL_W = $bits(t_tok_ctl);

endpackage

FILE: rtl/core/stf3_mod.sv
// ----------------------------------------------------------------------------
// stf3_mod
// Bit-serial remainder unit: (time level + 1) mod filter interval.
// ----------------------------------------------------------------------------
module stf3_mod (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [stf3_pkg::TIME_W:0]     i_dividend,
    input  logic [stf3_pkg::INT_W-1:0]    i_divisor,
    output logic                          o_busy,
    output logic                          o_rem_zero
);
    localparam int DVD_W = stf3_pkg::TIME_W + 1;
    localparam int CNT_W = $clog2(DVD_W + 1);

    logic                          r_busy;
    logic [CNT_W-1:0]              r_cnt;
    logic [DVD_W-1:0]              r_dvd;
    logic [stf3_pkg::INT_W-1:0]    r_dvs;
    logic [stf3_pkg::INT_W-1:0]    r_rem;
    logic [stf3_pkg::INT_W:0]      w_shift;
    logic [stf3_pkg::INT_W:0]      w_diff;

    assign w_shift = {r_rem, r_dvd[DVD_W-1]};
    assign w_diff  = w_shift - {1'b0, r_dvs};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= CNT_W'(DVD_W);
        end else if (r_busy) begin
            r_cnt <= r_cnt - 1'b1;
            if (r_cnt == CNT_W'(1)) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_dvd <= i_dividend;
            r_dvs <= i_divisor;
            r_rem <= '0;
        end else if (r_busy) begin
            r_dvd <= {r_dvd[DVD_W-2:0], 1'b0};
            if (w_shift >= {1'b0, r_dvs}) begin
                r_rem <= w_diff[stf3_pkg::INT_W-1:0];
            end else begin
                r_rem <= w_shift[stf3_pkg::INT_W-1:0];
            end
        end
    end

    assign o_busy     = r_busy;
    assign o_rem_zero = (r_rem == '0);

endmodule

FILE: rtl/core/stf3_queue.sv
// ----------------------------------------------------------------------------
// stf3_queue
// Short token queue between the front and the back of the filter.
// ----------------------------------------------------------------------------
module stf3_queue #(
    parameter int W     = 20,
    parameter int DEPTH = 2
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_push,
    input  logic [W-1:0] i_data,
    input  logic         i_pop,
    output logic [W-1:0] o_data,
    output logic         o_full,
    output logic         o_empty
);
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [W-1:0]     r_mem [DEPTH];
    logic [PTR_W-1:0] r_wptr;
    logic [PTR_W-1:0] r_rptr;
    logic [CNT_W-1:0] r_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= '0;
            r_rptr <= '0;
            r_cnt  <= '0;
        end else begin
            if (i_push) begin
                r_wptr <= (r_wptr == PTR_W'(DEPTH - 1)) ? '0 : r_wptr + 1'b1;
            end
            if (i_pop) begin
                r_rptr <= (r_rptr == PTR_W'(DEPTH - 1)) ? '0 : r_rptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (!i_push && i_pop) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_data;
        end
    end

    assign o_data  = r_mem[r_rptr];
    assign o_full  = (r_cnt == CNT_W'(DEPTH));
    assign o_empty = (r_cnt == '0);

endmodule

FILE: rtl/core/stf3_win.sv
// ----------------------------------------------------------------------------
// stf3_win
// Window store: two planes plus a row of samples, one write and one read port.
// ----------------------------------------------------------------------------
module stf3_win #(
    parameter int DEPTH = 131328,
    parameter int AW    = 18
) (
    input  logic                            i_clk,
    input  logic                            i_wr_en,
    input  logic [AW-1:0]                   i_wr_addr,
    input  logic [stf3_pkg::SAMPLE_W-1:0]   i_wr_data,
    input  logic                            i_rd_en,
    input  logic [AW-1:0]                   i_rd_addr,
    output logic [stf3_pkg::SAMPLE_W-1:0]   o_rd_data
);
    logic [stf3_pkg::SAMPLE_W-1:0] r_mem [DEPTH];
    logic [stf3_pkg::SAMPLE_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rdata <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rdata;

endmodule

FILE: rtl/core/stf3_front.sv
// ----------------------------------------------------------------------------
// stf3_front
// Accepts words, stores samples, tracks grid positions and issues one token
// per point that is ready to be emitted.
// ----------------------------------------------------------------------------
module stf3_front #(
    parameter  int MAX_DIM = 256,
    localparam int DW      = $clog2(MAX_DIM + 1),
    localparam int PLW     = $clog2(MAX_DIM * MAX_DIM + 1),
    localparam int PW      = $clog2(MAX_DIM * MAX_DIM * MAX_DIM + 1),
    localparam int WIN     = 2 * MAX_DIM * MAX_DIM + MAX_DIM,
    localparam int AW      = $clog2(WIN),
    localparam int TW      = AW + stf3_pkg::TOK_CTL_W
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  logic [stf3_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [stf3_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    input  logic                               i_valid,
    output logic                               o_stall,
    input  logic                               i_op,
    input  logic signed [stf3_pkg::SAMPLE_W-1:0] i_sample,
    input  logic [stf3_pkg::TIME_W-1:0]        i_time_level,
    input  logic                               i_q_full,
    input  logic                               i_q_empty,
    output logic                               o_q_push,
    output logic [TW-1:0]                      o_q_data,
    input  logic                               i_back_idle,
    output logic                               o_wr_en,
    output logic [AW-1:0]                      o_wr_addr,
    output logic [stf3_pkg::SAMPLE_W-1:0]      o_wr_data,
    output logic [DW-1:0]                      o_sk,
    output logic [PLW-1:0]                     o_plane
);
    localparam logic F_RUN = 1'b0;
    localparam logic F_MOD = 1'b1;

    function automatic logic [DW-1:0] f_clamp(input logic [stf3_pkg::DIM_CFG_W-1:0] v);
        logic [DW-1:0] r;
        if (int'(v) < 3) begin
            r = DW'(3);
        end else if (int'(v) > MAX_DIM) begin
            r = DW'(MAX_DIM);
        end else begin
            r = DW'(v);
        end
        return r;
    endfunction

    // configuration
    logic [stf3_pkg::DIM_CFG_W-1:0] r_cfg_si, r_cfg_sj, r_cfg_sk;
    logic [stf3_pkg::INT_W-1:0]     r_cfg_int;
    logic [DW-1:0]                  w_si, w_sj, w_sk;
    logic [PLW-1:0]                 r_plane;
    logic [PW-1:0]                  r_total;

    // control state
    logic        r_state, n_state;
    logic [1:0]  r_cfg_wait, n_cfg_wait;
    logic [PW-1:0] r_in_pos, n_in_pos, r_out_pos, n_out_pos;
    logic [AW-1:0] r_waddr, n_waddr, r_raddr, n_raddr;
    logic [DW-1:0] r_ci, n_ci, r_cj, n_cj, r_ck, n_ck;
    logic        r_filt_act, n_filt_act;
    logic        r_have_filt, n_have_filt;
    logic        r_filt_next, n_filt_next;

    logic        w_cfg_hit, w_stall, w_acc, w_first, w_need, w_ready_new;
    logic        w_mod_start, w_mod_busy, w_mod_zero;
    logic        w_store, w_emit, w_last, w_filt;
    logic [PW-1:0] w_in_next;
    logic [PW:0]   w_ahead;
    stf3_pkg::t_tok_ctl w_ctl;

    assign w_si = f_clamp(r_cfg_si);
    assign w_sj = f_clamp(r_cfg_sj);
    assign w_sk = f_clamp(r_cfg_sk);

    assign w_cfg_hit = i_cfg_we && (i_cfg_index == stf3_pkg::REG_SIZE_I ||
                                    i_cfg_index == stf3_pkg::REG_SIZE_J ||
                                    i_cfg_index == stf3_pkg::REG_SIZE_K ||
                                    i_cfg_index == stf3_pkg::REG_INTERVAL);

    assign w_first = (i_op == stf3_pkg::OP_SAMPLE) && (r_in_pos == '0);
    assign w_need  = i_valid && w_first && !r_have_filt;
    assign w_stall = (r_cfg_wait != '0) || (r_state != F_RUN) || i_q_full || w_need;
    assign w_acc   = i_valid && !w_stall;

    // a new grid starts only once the back has finished with the old one
    assign w_ready_new = (r_state == F_RUN) && w_need && (r_cfg_wait == '0) &&
                         i_back_idle && i_q_empty && !w_mod_busy;
    assign w_mod_start = w_ready_new && (r_cfg_int != '0);

    assign w_store   = w_acc && (i_op == stf3_pkg::OP_SAMPLE) && (r_in_pos < r_total);
    assign w_in_next = w_store ? r_in_pos + 1'b1 : r_in_pos;
    assign w_ahead   = {1'b0, r_out_pos} + (PW + 1)'(r_plane);
    assign w_emit    = w_acc && (r_out_pos < w_in_next) &&
                       ((w_ahead < {1'b0, w_in_next}) || (w_in_next >= r_total));
    assign w_last    = (r_out_pos + 1'b1 == r_total);
    assign w_filt    = (w_store && r_in_pos == '0) ? r_filt_next : r_filt_act;

    always_comb begin
        w_ctl.interior = w_filt &&
                         r_ci != '0 && r_ci != w_si - 1'b1 &&
                         r_cj != '0 && r_cj != w_sj - 1'b1 &&
                         r_ck != '0 && r_ck != w_sk - 1'b1;
        w_ctl.last = w_last;
    end

    stf3_mod u_mod (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_mod_start),
        .i_dividend ({1'b0, i_time_level} + (stf3_pkg::TIME_W + 1)'(1)),
        .i_divisor  (r_cfg_int),
        .o_busy     (w_mod_busy),
        .o_rem_zero (w_mod_zero)
    );

    always_comb begin
        n_state     = r_state;
        n_cfg_wait  = r_cfg_wait;
        n_in_pos    = r_in_pos;
        n_out_pos   = r_out_pos;
        n_waddr     = r_waddr;
        n_raddr     = r_raddr;
        n_ci        = r_ci;
        n_cj        = r_cj;
        n_ck        = r_ck;
        n_filt_act  = r_filt_act;
        n_have_filt = r_have_filt;
        n_filt_next = r_filt_next;

        if (r_cfg_wait != '0) begin
            n_cfg_wait = r_cfg_wait - 1'b1;
        end

        case (r_state)
            F_RUN: begin
                if (w_mod_start) begin
                    n_state = F_MOD;
                end else if (w_ready_new) begin
                    n_have_filt = 1'b1;
                    n_filt_next = 1'b0;
                end
            end
            F_MOD: begin
                if (!w_mod_busy) begin
                    n_state     = F_RUN;
                    n_have_filt = 1'b1;
                    n_filt_next = w_mod_zero;
                end
            end
            default: begin
                n_state = F_RUN;
            end
        endcase

        if (w_store) begin
            n_in_pos = r_in_pos + 1'b1;
            n_waddr  = (r_waddr == AW'(WIN - 1)) ? '0 : r_waddr + 1'b1;
            if (r_in_pos == '0) begin
                n_filt_act  = r_filt_next;
                n_have_filt = 1'b0;
            end
        end

        if (w_emit) begin
            n_out_pos = r_out_pos + 1'b1;
            n_raddr   = (r_raddr == AW'(WIN - 1)) ? '0 : r_raddr + 1'b1;
            if (r_ck == w_sk - 1'b1) begin
                n_ck = '0;
                if (r_cj == w_sj - 1'b1) begin
                    n_cj = '0;
                    n_ci = r_ci + 1'b1;
                end else begin
                    n_cj = r_cj + 1'b1;
                end
            end else begin
                n_ck = r_ck + 1'b1;
            end
        end

        // last point of the grid or a config write: start over
        if ((w_emit && w_last) || w_cfg_hit) begin
            n_in_pos   = '0;
            n_out_pos  = '0;
            n_waddr    = '0;
            n_raddr    = '0;
            n_ci       = '0;
            n_cj       = '0;
            n_ck       = '0;
            n_filt_act = 1'b0;
        end

        if (w_cfg_hit) begin
            n_state     = F_RUN;
            n_cfg_wait  = stf3_pkg::CFG_SETTLE;
            n_have_filt = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= F_RUN;
            r_cfg_wait  <= stf3_pkg::CFG_SETTLE;
            r_in_pos    <= '0;
            r_out_pos   <= '0;
            r_waddr     <= '0;
            r_raddr     <= '0;
            r_ci        <= '0;
            r_cj        <= '0;
            r_ck        <= '0;
            r_filt_act  <= 1'b0;
            r_have_filt <= 1'b0;
            r_filt_next <= 1'b0;
            r_cfg_si    <= stf3_pkg::DIM_CFG_W'(3);
            r_cfg_sj    <= stf3_pkg::DIM_CFG_W'(3);
            r_cfg_sk    <= stf3_pkg::DIM_CFG_W'(3);
            r_cfg_int   <= '0;
        end else begin
            r_state     <= n_state;
            r_cfg_wait  <= n_cfg_wait;
            r_in_pos    <= n_in_pos;
            r_out_pos   <= n_out_pos;
            r_waddr     <= n_waddr;
            r_raddr     <= n_raddr;
            r_ci        <= n_ci;
            r_cj        <= n_cj;
            r_ck        <= n_ck;
            r_filt_act  <= n_filt_act;
            r_have_filt <= n_have_filt;
            r_filt_next <= n_filt_next;
            if (i_cfg_we) begin
                case (i_cfg_index)
                    stf3_pkg::REG_SIZE_I:   r_cfg_si  <= i_cfg_data[stf3_pkg::DIM_CFG_W-1:0];
                    stf3_pkg::REG_SIZE_J:   r_cfg_sj  <= i_cfg_data[stf3_pkg::DIM_CFG_W-1:0];
                    stf3_pkg::REG_SIZE_K:   r_cfg_sk  <= i_cfg_data[stf3_pkg::DIM_CFG_W-1:0];
                    stf3_pkg::REG_INTERVAL: r_cfg_int <= i_cfg_data[stf3_pkg::INT_W-1:0];
                    default: begin
                    end
                endcase
            end
        end
    end

    // size products settle through r_plane then r_total, covered by the settle count
    always_ff @(posedge i_clk) begin
        r_plane <= PLW'(w_sj) * PLW'(w_sk);
        r_total <= PW'(r_plane) * PW'(w_si);
    end

    assign o_stall   = w_stall;
    assign o_q_push  = w_emit;
    assign o_q_data  = {r_raddr, w_ctl};
    assign o_wr_en   = w_store;
    assign o_wr_addr = r_waddr;
    assign o_wr_data = i_sample;
    assign o_sk      = w_sk;
    assign o_plane   = r_plane;

endmodule

FILE: rtl/core/stf3_back.sv
// ----------------------------------------------------------------------------
// stf3_back
// Reads centre and, if interior, six neighbors; weighted sum over 12, rounded
// and saturated (a face point gives its centre); holds the result word.
// ----------------------------------------------------------------------------
module stf3_back #(
    parameter  int MAX_DIM = 256,
    localparam int DW      = $clog2(MAX_DIM + 1),
    localparam int PLW     = $clog2(MAX_DIM * MAX_DIM + 1),
    localparam int WIN     = 2 * MAX_DIM * MAX_DIM + MAX_DIM,
    localparam int AW      = $clog2(WIN),
    localparam int TW      = AW + stf3_pkg::TOK_CTL_W
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic [TW-1:0]                      i_q_data,
    input  logic                               i_q_empty,
    output logic                               o_q_pop,
    input  logic [DW-1:0]                      i_sk,
    input  logic [PLW-1:0]                     i_plane,
    output logic                               o_rd_en,
    output logic [AW-1:0]                      o_rd_addr,
    input  logic [stf3_pkg::SAMPLE_W-1:0]      i_rd_data,
    output logic                               o_idle,
    output logic                               o_valid,
    input  logic                               i_stall,
    output logic signed [stf3_pkg::SAMPLE_W-1:0] o_filtered,
    output logic                               o_last_of_grid
);
    localparam logic [2:0] B_IDLE = 3'd0;
    localparam logic [2:0] B_READ = 3'd1;
    localparam logic [2:0] B_WAIT = 3'd2;
    localparam logic [2:0] B_MUL  = 3'd3;
    localparam logic [2:0] B_FIX  = 3'd4;
    localparam logic [2:0] B_OUT  = 3'd5;

    localparam int ACC_W = stf3_pkg::ACC_W;
    localparam int SW    = stf3_pkg::SAMPLE_W;
    localparam int YW    = stf3_pkg::DIV_Y_W;
    localparam int QW    = YW + 1;

    logic [2:0]             r_state;
    logic [AW-1:0]          r_addr;
    stf3_pkg::t_tok_ctl     r_ctl;
    logic [2:0]             r_ridx;
    logic                   r_rd_pend;
    logic [2:0]             r_rd_idx_d;
    logic signed [ACC_W-1:0] r_acc;
    logic signed [SW-1:0]   r_center;
    logic                   r_neg;
    logic [YW-1:0]          r_y;
    logic [2*YW-1:0]        r_prod;
    logic signed [SW-1:0]   r_res;
    logic                   r_out_valid;
    logic signed [SW-1:0]   r_out_data;
    logic                   r_out_last;

    logic [AW-1:0]          w_off;
    logic                   w_minus;
    logic [AW:0]            w_sum;
    logic [AW-1:0]          w_naddr;
    logic signed [ACC_W-1:0] w_rd_ext;
    logic [ACC_W-1:0]       w_abs;
    logic [ACC_W-1:0]       w_x;
    logic [QW-1:0]          w_q0, w_q;
    logic [QW:0]            w_rem;
    logic signed [QW:0]     w_sq;
    logic                   w_out_free;
    logic                   w_rd_last;

    assign w_out_free = !r_out_valid || !i_stall;
    assign w_rd_last  = (r_ridx == stf3_pkg::NB_IM) || !r_ctl.interior;

    // neighbor address, wrapped around the window store
    always_comb begin
        case (r_ridx)
            stf3_pkg::NB_CENTER: begin w_off = '0;              w_minus = 1'b0; end
            stf3_pkg::NB_KP:     begin w_off = AW'(1);          w_minus = 1'b0; end
            stf3_pkg::NB_KM:     begin w_off = AW'(1);          w_minus = 1'b1; end
            stf3_pkg::NB_JP:     begin w_off = AW'(i_sk);       w_minus = 1'b0; end
            stf3_pkg::NB_JM:     begin w_off = AW'(i_sk);       w_minus = 1'b1; end
            stf3_pkg::NB_IP:     begin w_off = AW'(i_plane);    w_minus = 1'b0; end
            stf3_pkg::NB_IM:     begin w_off = AW'(i_plane);    w_minus = 1'b1; end
            default:             begin w_off = '0;              w_minus = 1'b0; end
        endcase
        if (w_minus) begin
            if (r_addr >= w_off) begin
                w_sum = {1'b0, r_addr} - {1'b0, w_off};
            end else begin
                w_sum = {1'b0, r_addr} + (AW + 1)'(WIN) - {1'b0, w_off};
            end
        end else begin
            w_sum = {1'b0, r_addr} + {1'b0, w_off};
            if (w_sum >= (AW + 1)'(WIN)) begin
                w_sum = w_sum - (AW + 1)'(WIN);
            end
        end
        w_naddr = w_sum[AW-1:0];
    end

    assign w_rd_ext = ACC_W'($signed(i_rd_data));
    assign w_abs    = r_acc[ACC_W-1] ? ACC_W'(-r_acc) : ACC_W'(r_acc);
    assign w_x      = w_abs + ACC_W'(6);

    // one correction step after the reciprocal multiply
    always_comb begin
        w_q0  = QW'(r_prod[2*YW-1:stf3_pkg::RECIP_SH]);
        w_rem = (QW + 1)'(r_y) - (QW + 1)'(w_q0) * (QW + 1)'(3);
        w_q   = (w_rem >= (QW + 1)'(3)) ? w_q0 + 1'b1 : w_q0;
        w_sq  = r_neg ? -$signed({1'b0, w_q}) : $signed({1'b0, w_q});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= B_IDLE;
            r_ridx      <= stf3_pkg::NB_CENTER;
            r_rd_pend   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_rd_pend <= (r_state == B_READ);
            if (r_state == B_OUT && w_out_free) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && !i_stall) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                B_IDLE: begin
                    if (!i_q_empty) begin
                        r_ridx  <= stf3_pkg::NB_CENTER;
                        r_state <= B_READ;
                    end
                end
                B_READ: begin
                    if (w_rd_last) begin
                        r_state <= B_WAIT;
                    end else begin
                        r_ridx <= r_ridx + 1'b1;
                    end
                end
                B_WAIT: begin
                    // hold until the last read has been summed
                    if (!r_rd_pend) begin
                        r_state <= r_ctl.interior ? B_MUL : B_OUT;
                    end
                end
                B_MUL: begin
                    r_state <= B_FIX;
                end
                B_FIX: begin
                    r_state <= B_OUT;
                end
                B_OUT: begin
                    if (w_out_free) begin
                        r_state <= B_IDLE;
                    end
                end
                default: begin
                    r_state <= B_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == B_IDLE && !i_q_empty) begin
            r_addr <= i_q_data[TW-1:stf3_pkg::TOK_CTL_W];
            r_ctl  <= i_q_data[stf3_pkg::TOK_CTL_W-1:0];
        end
        if (r_state == B_READ) begin
            r_rd_idx_d <= r_ridx;
        end
        if (r_rd_pend) begin
            if (r_rd_idx_d == stf3_pkg::NB_CENTER) begin
                r_acc    <= (w_rd_ext <<< 2) + (w_rd_ext <<< 1);
                r_center <= $signed(i_rd_data);
            end else begin
                r_acc <= r_acc + w_rd_ext;
            end
        end
        if (r_state == B_WAIT && !r_rd_pend) begin
            r_neg <= r_acc[ACC_W-1];
            r_y   <= YW'(w_x >> 2);
            r_res <= r_center;
        end
        if (r_state == B_MUL) begin
            r_prod <= r_y * stf3_pkg::RECIP3;
        end
        if (r_state == B_FIX) begin
            if (w_sq > (QW + 1)'($signed(24'sh7FFFFF))) begin
                r_res <= 24'sh7FFFFF;
            end else if (w_sq < (QW + 1)'($signed(24'sh800000))) begin
                r_res <= 24'sh800000;
            end else begin
                r_res <= SW'(w_sq);
            end
        end
        if (r_state == B_OUT && w_out_free) begin
            r_out_data <= r_res;
            r_out_last <= r_ctl.last;
        end
    end

    assign o_q_pop        = (r_state == B_IDLE) && !i_q_empty;
    assign o_rd_en        = (r_state == B_READ);
    assign o_rd_addr      = w_naddr;
    assign o_idle         = (r_state == B_IDLE);
    assign o_valid        = r_out_valid;
    assign o_filtered     = r_out_data;
    assign o_last_of_grid = r_out_last;

endmodule

FILE: rtl/core/stencil_filter_3d_seven_point_top.sv
// ----------------------------------------------------------------------------
// stencil_filter_3d_seven_point_top
// Seven-point 3D smoothing filter over a streamed grid of Q8.16 samples.
//
//  channel   dir  handshake          payload
//  input     in   i_valid/o_stall    i_op, i_sample, i_time_level
//  output    out  o_valid/i_stall    o_filtered, o_last_of_grid
//  config    in   i_cfg_we           i_cfg_index, i_cfg_data
//
// In the back a face point reads only the centre, and an interior point the
// centre plus six neighbors, one a cycle through the one read port of the
// window store, followed by the divide-by-twelve multiply and fix.
// The first sample of each grid waits for the back to drain, then stalls
// while the time-level remainder is found one bit a cycle (that step is
// skipped when the interval is zero).
// After reset and each config write the input stalls while the sizes settle.
// ----------------------------------------------------------------------------
module stencil_filter_3d_seven_point_top #(
    parameter int MAX_DIM = 256
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_cfg_we,
    input  logic [stf3_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [stf3_pkg::CFG_DATA_W-1:0]      i_cfg_data,
    input  logic                                 i_valid,
    output logic                                 o_stall,
    input  logic                                 i_op,
    input  logic signed [stf3_pkg::SAMPLE_W-1:0] i_sample,
    input  logic [stf3_pkg::TIME_W-1:0]          i_time_level,
    output logic                                 o_valid,
    input  logic                                 i_stall,
    output logic signed [stf3_pkg::SAMPLE_W-1:0] o_filtered,
    output logic                                 o_last_of_grid
);
    localparam int DW  = $clog2(MAX_DIM + 1);
    localparam int PLW = $clog2(MAX_DIM * MAX_DIM + 1);
    localparam int WIN = 2 * MAX_DIM * MAX_DIM + MAX_DIM;
    localparam int AW  = $clog2(WIN);
    localparam int TW  = AW + stf3_pkg::TOK_CTL_W;

    logic                          w_q_push, w_q_pop, w_q_full, w_q_empty;
    logic [TW-1:0]                 w_q_in, w_q_out;
    logic                          w_back_idle;
    logic                          w_wr_en, w_rd_en;
    logic [AW-1:0]                 w_wr_addr, w_rd_addr;
    logic [stf3_pkg::SAMPLE_W-1:0] w_wr_data, w_rd_data;
    logic [DW-1:0]                 w_sk;
    logic [PLW-1:0]                w_plane;

    stf3_front #(.MAX_DIM(MAX_DIM)) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_op         (i_op),
        .i_sample     (i_sample),
        .i_time_level (i_time_level),
        .i_q_full     (w_q_full),
        .i_q_empty    (w_q_empty),
        .o_q_push     (w_q_push),
        .o_q_data     (w_q_in),
        .i_back_idle  (w_back_idle),
        .o_wr_en      (w_wr_en),
        .o_wr_addr    (w_wr_addr),
        .o_wr_data    (w_wr_data),
        .o_sk         (w_sk),
        .o_plane      (w_plane)
    );

    stf3_queue #(.W(TW), .DEPTH(stf3_pkg::QDEPTH)) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_q_push),
        .i_data  (w_q_in),
        .i_pop   (w_q_pop),
        .o_data  (w_q_out),
        .o_full  (w_q_full),
        .o_empty (w_q_empty)
    );

    stf3_win #(.DEPTH(WIN), .AW(AW)) u_win (
        .i_clk     (i_clk),
        .i_wr_en   (w_wr_en),
        .i_wr_addr (w_wr_addr),
        .i_wr_data (w_wr_data),
        .i_rd_en   (w_rd_en),
        .i_rd_addr (w_rd_addr),
        .o_rd_data (w_rd_data)
    );

    stf3_back #(.MAX_DIM(MAX_DIM)) u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_q_data       (w_q_out),
        .i_q_empty      (w_q_empty),
        .o_q_pop        (w_q_pop),
        .i_sk           (w_sk),
        .i_plane        (w_plane),
        .o_rd_en        (w_rd_en),
        .o_rd_addr      (w_rd_addr),
        .i_rd_data      (w_rd_data),
        .o_idle         (w_back_idle),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_filtered     (o_filtered),
        .o_last_of_grid (o_last_of_grid)
    );

endmodule

FILE: rtl/core/stf3_chk.sv
// ----------------------------------------------------------------------------
// stf3_chk
// Port-level checks of the stencil filter, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module stf3_chk (
    input logic                                 i_clk,
    input logic                                 i_rst_n,
    input logic                                 i_cfg_we,
    input logic                                 o_stall,
    input logic                                 o_valid,
    input logic                                 i_stall,
    input logic signed [stf3_pkg::SAMPLE_W-1:0] o_filtered,
    input logic                                 o_last_of_grid
);
    // a stalled result word holds
    `STF3_ASSERT_NXT(a_out_hold, i_clk, i_rst_n, o_valid && i_stall, o_valid && $stable(o_filtered) && $stable(o_last_of_grid))

    // a config write blocks input while the grid size settles
    `STF3_ASSERT_NXT(a_cfg_settle, i_clk, i_rst_n, i_cfg_we, o_stall)

    // a grid has at least 27 points, so two last words never follow each other
    `STF3_ASSERT_NXT(a_last_once, i_clk, i_rst_n, o_valid && !i_stall && o_last_of_grid, !(o_valid && o_last_of_grid))

endmodule

bind stencil_filter_3d_seven_point_top stf3_chk u_chk (.*);
